// File: hw/rtl/aacd_pkg.sv
// ----------------------------------------------------------------------------
// aacd_pkg: shared definitions for the averaging change detector
// Widths, register indexes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package aacd_pkg;

  // Sizes
  localparam int MAX_WINDOW = 64;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int WIN_W      = 7;
  localparam int SAMPLE_W   = 10;
  localparam int TOTAL_W    = 16;
  localparam int LEVEL_W    = 16;
  localparam int SPAN_W     = LEVEL_W + 1;
  localparam int PROD_W     = 28;
  localparam int MAG_W      = 26;
  localparam int QUOT_W     = 17;
  localparam int REM_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = $clog2(TOTAL_W + 1);

  localparam logic [WIN_W-1:0]  WIN_MAX    = WIN_W'(MAX_WINDOW);
  localparam logic [REM_W-1:0]  FULL_SCALE = REM_W'(1023);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE = 2'd0,
    REG_OUT_LOW     = 2'd1,
    REG_OUT_HIGH    = 2'd2
  } cfg_reg_t;

  // Controller states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_TOTAL = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_RECIP = 8'b0001_0000,
    ST_CORR1 = 8'b0010_0000,
    ST_CORR2 = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_sample;
    logic update_total;
    logic take_quot;
    logic multiply;
    logic recip;
    logic correct;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic avg_en;
    logic map_en;
    logic div_done;
    logic emit;
    logic out_full;
  } status_t;

endpackage

// File: hw/rtl/aacd_div.sv
// ----------------------------------------------------------------------------
// aacd_div: serial restoring divider
// Running total over window size, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aacd_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [aacd_pkg::TOTAL_W-1:0]    dividend,
  input  logic [aacd_pkg::WIN_W-1:0]      divisor,
  output logic                            busy,
  output logic [aacd_pkg::TOTAL_W-1:0]    quotient
);
  import aacd_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [WIN_W-1:0]     rem;
  logic [WIN_W-1:0]     dvsr;
  logic [WIN_W:0]       rem_shift;
  logic                 fits;

  // Trial subtract of the shifted remainder
  assign rem_shift = {rem, quotient[TOTAL_W-1]};
  assign fits      = rem_shift >= {1'b0, dvsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(TOTAL_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift/subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvsr     <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= WIN_W'(rem_shift - {1'b0, dvsr});
      end else begin
        rem <= rem_shift[WIN_W-1:0];
      end
      quotient <= {quotient[TOTAL_W-2:0], fits};
    end
  end

endmodule

// File: hw/rtl/aacd_dp.sv
// ----------------------------------------------------------------------------
// aacd_dp: datapath of the averaging change detector
// Configuration registers, sample ring, running total, divider, linear map
// with divide-by-full-scale, change detect and the result register.
// ----------------------------------------------------------------------------
module aacd_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [aacd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aacd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [aacd_pkg::SAMPLE_W-1:0]     adc_sample,
  input  aacd_pkg::cmd_t                    cmd,
  output aacd_pkg::status_t                 status,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [aacd_pkg::LEVEL_W-1:0] level,
  output logic                              rising
);
  import aacd_pkg::*;

  // Configuration
  logic [WIN_W-1:0]          window_size;
  logic signed [LEVEL_W-1:0] out_low;
  logic signed [LEVEL_W-1:0] out_high;
  logic [WIN_W-1:0]          win_sat;
  logic                      win_write;

  // Ring store and total
  logic [SAMPLE_W-1:0]   store_mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] store_vld;
  logic [SAMPLE_W-1:0]   rd_data;
  logic                  rd_vld;
  logic [SLOT_W-1:0]     write_slot;
  logic [WIN_W-1:0]      slot_inc;
  logic [TOTAL_W-1:0]    window_total;
  logic [TOTAL_W-1:0]    total_next;
  logic [SAMPLE_W-1:0]   sample;

  // Working value and divider
  logic [SAMPLE_W-1:0] work;
  logic                div_busy;
  logic [TOTAL_W-1:0]  quot;

  // Mapping
  logic signed [SPAN_W-1:0] span;
  logic signed [PROD_W-1:0] work_ext;
  logic signed [PROD_W-1:0] span_ext;
  logic signed [PROD_W-1:0] prod;
  logic [MAG_W-1:0]         mag;
  logic                     neg;
  logic [MAG_W:0]           mag_sum;
  logic [QUOT_W-1:0]        q0;
  logic [MAG_W:0]           q0_times;
  logic [MAG_W:0]           r_full;
  logic [QUOT_W-1:0]        map_q;
  logic [REM_W-1:0]         map_r;
  logic [QUOT_W:0]          q_signed;
  logic [QUOT_W:0]          map_sum;

  // Change detect
  logic signed [LEVEL_W-1:0] last_level;
  logic signed [LEVEL_W-1:0] level_next;

  // Config write decode, window size saturates at the store depth
  assign win_write = cfg_write && (cfg_index == REG_WINDOW_SIZE);
  assign win_sat   = (cfg_data[WIN_W-1:0] > WIN_MAX) ? WIN_MAX : cfg_data[WIN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= '0;
      out_low     <= '0;
      out_high    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_SIZE: window_size <= win_sat;
        REG_OUT_LOW:     out_low     <= cfg_data;
        REG_OUT_HIGH:    out_high    <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Ring memory: read at accept, write during the total update
  always_ff @(posedge clk) begin
    if (cmd.update_total) begin
      store_mem[write_slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      rd_data <= store_mem[write_slot];
      rd_vld  <= store_vld[write_slot];
    end
  end

  // Unwritten entries read as zero
  assign total_next = window_total + TOTAL_W'(sample)
                      - (rd_vld ? TOTAL_W'(rd_data) : TOTAL_W'(0));
  assign slot_inc   = WIN_W'(write_slot) + WIN_W'(1);

  always_ff @(posedge clk) begin
    if (rst || win_write) begin
      store_vld    <= '0;
      window_total <= '0;
      write_slot   <= '0;
    end else if (cmd.update_total) begin
      store_vld[write_slot] <= 1'b1;
      window_total          <= total_next;
      write_slot            <= (slot_inc >= window_size) ? '0 : slot_inc[SLOT_W-1:0];
    end
  end

  // Sample and working value
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample <= adc_sample;
      work   <= adc_sample;
    end else if (cmd.take_quot) begin
      work <= quot[SAMPLE_W-1:0];
    end
  end

  aacd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.update_total),
    .dividend (total_next),
    .divisor  (window_size),
    .busy     (div_busy),
    .quotient (quot)
  );

  // Product of working value and output span
  assign span     = SPAN_W'(out_high) - SPAN_W'(out_low);
  assign work_ext = {{(PROD_W-SAMPLE_W){1'b0}}, work};
  assign span_ext = {{(PROD_W-SPAN_W){span[SPAN_W-1]}}, span};

  always_ff @(posedge clk) begin
    if (cmd.multiply) begin
      prod <= work_ext * span_ext;
    end
  end

  // Divide magnitude by full scale: estimate, then at most two corrections
  assign mag      = prod[PROD_W-1] ? MAG_W'(-prod) : prod[MAG_W-1:0];
  assign mag_sum  = {1'b0, mag} + (MAG_W+1)'(mag[MAG_W-1:10]);
  assign q0       = mag_sum[MAG_W:10];
  assign q0_times = {q0, 10'b0} - (MAG_W+1)'(q0);
  assign r_full   = {1'b0, mag} - q0_times;

  always_ff @(posedge clk) begin
    if (cmd.recip) begin
      neg   <= prod[PROD_W-1];
      map_q <= q0;
      map_r <= r_full[REM_W-1:0];
    end else if (cmd.correct && (map_r >= FULL_SCALE)) begin
      map_q <= map_q + 1'b1;
      map_r <= map_r - FULL_SCALE;
    end
  end

  // Final level, truncated toward zero then offset
  assign q_signed   = neg ? -{1'b0, map_q} : {1'b0, map_q};
  assign map_sum    = q_signed + {{(QUOT_W+1-LEVEL_W){out_low[LEVEL_W-1]}}, out_low};
  assign level_next = status.map_en ? map_sum[LEVEL_W-1:0]
                                    : LEVEL_W'(work);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= '0;
    end else if (cmd.finish) begin
      last_level <= level_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish && status.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && status.emit) begin
      level  <= level_next;
      rising <= level_next > last_level;
    end
  end

  // Status
  assign status.avg_en   = window_size != '0;
  assign status.map_en   = out_high != '0;
  assign status.div_done = !div_busy;
  assign status.emit     = level_next != last_level;
  assign status.out_full = result_valid && result_stall;

endmodule

// File: hw/rtl/aacd_ctrl.sv
// ----------------------------------------------------------------------------
// aacd_ctrl: sequencing controller
// Steps one sample through total update, division, mapping and change
// detection, then returns to idle.
// ----------------------------------------------------------------------------
module aacd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  aacd_pkg::status_t status,
  output aacd_pkg::cmd_t    cmd
);
  import aacd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign sample_stall = state != ST_IDLE;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.load_sample = 1'b1;
          state_next      = status.avg_en ? ST_TOTAL : ST_MUL;
        end
      end
      ST_TOTAL: begin
        cmd.update_total = 1'b1;
        state_next       = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.take_quot = 1'b1;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.multiply = 1'b1;
        state_next   = status.map_en ? ST_RECIP : ST_FIN;
      end
      ST_RECIP: begin
        cmd.recip  = 1'b1;
        state_next = ST_CORR1;
      end
      ST_CORR1: begin
        cmd.correct = 1'b1;
        state_next  = ST_CORR2;
      end
      ST_CORR2: begin
        cmd.correct = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        // hold while a pending result cannot be replaced
        if (!(status.emit && status.out_full)) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/analog_average_change_detector_top.sv
// ----------------------------------------------------------------------------
// analog_average_change_detector_top: moving average with change detect
// Usage: one converter sample per transfer on the sample channel
// (sample_valid/sample_stall). Each sample is averaged over the last
// window_size samples (0 bypasses), optionally mapped linearly onto
// out_low..out_high (out_high of 0 bypasses), and a transfer on the result
// channel (result_valid/result_stall) carries level and rising only when the
// value differs from the previous one.
// With averaging and mapping an item goes from accept through total update,
// the 16-step serial divider, multiply, estimate and corrections to the
// result register; without averaging total update and divider are skipped,
// without mapping estimate and corrections. One item is in work at a time;
// the next sample is taken the cycle after the result register loads.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle;
// writing window_size clears the sample ring and total.
// Reset clears configuration, ring, total and the previous level.
// A stalled result holds; the next sample is still taken, but its own result
// waits in the final step until the pending one has been transferred.
// ----------------------------------------------------------------------------
module analog_average_change_detector_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [aacd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aacd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [aacd_pkg::SAMPLE_W-1:0]       adc_sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [aacd_pkg::LEVEL_W-1:0] level,
  output logic                                rising
);
  import aacd_pkg::*;

  cmd_t    cmd;
  status_t status;

  aacd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  aacd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .adc_sample   (adc_sample),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .level        (level),
    .rising       (rising)
  );

endmodule
